### rtl/ptpc_pkg.sv
// Shared types, constants and channel arithmetic for the page-turn pixel compositor.
`timescale 1ns / 1ps
package ptpc_pkg;

   localparam int NW = 24;
   localparam int DW = 12;

   localparam logic [1:0] CSR_WIDTH = 2'd0;
   localparam logic [1:0] CSR_PHASE = 2'd1;
   localparam logic [1:0] CSR_DIR   = 2'd2;

   localparam logic [31:0] CH_MASK    = 32'h0000_00ff;
   localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;

   typedef enum logic [2:0] {
      SEL_OLD, SEL_NEW, SEL_DK_OLD, SEL_DK_NEW, SEL_LIGHT, SEL_DARK
   } sel_type;

   typedef enum logic [2:0] {
      CFG_IDLE, CFG_LOAD, CFG_DIV, CFG_SQRT, CFG_ROUND, CFG_SETTLE
   } cfg_state_type;

   typedef struct packed {
      logic [12:0]        w;
      logic [11:0]        p;
      logic               dir;
      logic [11:0]        m;
      logic [7:0]         q;
      logic [6:0]         hg;
      logic [12:0]        b1;
      logic [12:0]        b2;
      logic [12:0]        b3;
      logic [12:0]        b4;
      logic               ph_zero;
      logic               ph_half;
      logic signed [15:0] s_lo;
      logic signed [15:0] s_hi;
   } cfg_type;

   typedef struct packed {
      sel_type     sel;
      logic [31:0] old_pixel;
      logic [31:0] new_pixel;
      logic [31:0] shifted;
      logic [6:0]  hg;
      logic        half;
   } pix_type;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [NW-1:0] nq;
      logic [DW-1:0] div;
      pix_type       pix;
   } stage_type;

   function automatic logic [12:0] clamp_w(input logic signed [15:0] v, input logic [12:0] w);
      logic [12:0] r;
      if (v < 16'sd0) r = '0;
      else if (v > $signed({3'b000, w})) r = w;
      else r = v[12:0];
      return r;
   endfunction

   function automatic logic [31:0] darken(input logic [31:0] c, input logic [31:0] f);
      logic [31:0] mask, t, prod, r;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         mask = CH_MASK << (8 * k);
         t    = c & mask;
         prod = t * f;
         r    = r | ((t - (prod >> 8)) & mask);
      end
      return r | (c & ALPHA_MASK);
   endfunction

   function automatic logic [31:0] lighten(input logic [31:0] c, input logic [31:0] f);
      logic [31:0] mask, t, prod, r;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         mask = CH_MASK << (8 * k);
         t    = c & mask;
         prod = (mask - t) * f;
         r    = r | (((prod >> 8) + t) & mask);
      end
      return r | (c & ALPHA_MASK);
   endfunction

   function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] al);
      logic [31:0] mask, x, y, prod, r;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         mask = CH_MASK << (8 * k);
         x    = a & mask;
         y    = b & mask;
         prod = (y - x) * al;
         r    = r | (((prod >> 8) + x) & mask);
      end
      return r;
   endfunction

endpackage

### rtl/page_turn_pixel_compositor.sv
// Page-turn pixel compositor top level.
//
//   channel  direction  handshake          beat
//   req      in         req_valid/stall    column, old, new, mirrored new pixel
//   rsp      out        rsp_valid/stall    composited pixel
//   csr      in         csr_write_enable   register index and data
//
// One pixel per clock while req is not stalled; two prep stages, 24 divide cells and
// two blend stages. The divide chain by phase or shade band sets the depth.
// A width, phase or direction write re-solves the crease strength with req_stall high.
// Synchronous reset leaves the pipeline empty and stalls req while the solver settles.
// A stalled rsp beat freezes the whole pipeline and stalls req.
`timescale 1ns / 1ps
module page_turn_pixel_compositor import ptpc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int SHADE_BAND = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_column,
   input  logic [31:0] req_old_pixel,
   input  logic [31:0] req_new_pixel,
   input  logic [31:0] req_new_pixel_shifted,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_pixel,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data
);

   logic      busy, adv, accept;
   cfg_type   cfg;
   logic      chain_valid [0:NW];
   stage_type chain_stage [0:NW];

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = busy || !adv;
   assign accept    = req_valid && !req_stall;

   ptpc_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .SHADE_BAND (SHADE_BAND)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .cfg              (cfg)
   );

   ptpc_prep u_prep (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .in_valid          (accept),
      .column            (req_column),
      .old_pixel         (req_old_pixel),
      .new_pixel         (req_new_pixel),
      .new_pixel_shifted (req_new_pixel_shifted),
      .cfg               (cfg),
      .out_valid         (chain_valid[0]),
      .out_stage         (chain_stage[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      ptpc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   ptpc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (chain_valid[NW]),
      .in_stage  (chain_stage[NW]),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_out_pixel)
   );

endmodule

### rtl/ptpc_cfg.sv
// Control registers, crease strength solver and band bound precompute.
`timescale 1ns / 1ps
module ptpc_cfg import ptpc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int SHADE_BAND = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data,
   output logic        busy,
   output cfg_type     cfg
);

   logic [12:0]   width_ff;
   logic [11:0]   phase_ff;
   logic          dir_ff;
   cfg_state_type state_ff, state_in;
   logic [12:0]   rem_ff;
   logic [27:0]   quo_ff;
   logic [4:0]    cnt_ff;
   logic [8:0]    root_ff;
   logic [7:0]    strength_ff;
   cfg_type       cfg_ff, cfg_in;

   logic               wr_hit;
   logic [12:0]        weff, div_w;
   logic [11:0]        half, m;
   logic [27:0]        num;
   logic [13:0]        rem_s;
   logic               ge;
   logic [15:0]        area;
   logic [8:0]         trial;
   logic [17:0]        trial_sq, root_sq, round_lim;
   logic signed [15:0] ws, ps, ms, p3h;

   assign wr_hit = csr_write_enable && (csr_index inside {CSR_WIDTH, CSR_PHASE, CSR_DIR});

   assign weff  = (32'(width_ff) > MAX_WIDTH) ? 13'(MAX_WIDTH) : width_ff;
   assign div_w = (weff == '0) ? 13'd1 : weff;
   assign half  = weff[12:1];
   assign num   = (weff != '0 && half > phase_ff) ? {half - phase_ff, 16'h0000} : '0;
   assign rem_s = {rem_ff, quo_ff[27]};
   assign ge    = rem_s >= {1'b0, div_w};
   assign area  = quo_ff[16:1];
   assign trial = root_ff | (9'd1 << cnt_ff[2:0]);
   assign trial_sq  = trial * trial;
   assign root_sq   = root_ff * root_ff;
   assign round_lim = root_sq + {9'd0, root_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CFG_IDLE:   state_in = CFG_IDLE;
         CFG_LOAD:   state_in = CFG_DIV;
         CFG_DIV:    if (cnt_ff == '0) state_in = CFG_SQRT;
         CFG_SQRT:   if (cnt_ff == '0) state_in = CFG_ROUND;
         CFG_ROUND:  state_in = CFG_SETTLE;
         CFG_SETTLE: state_in = CFG_IDLE;
         default:    state_in = CFG_IDLE;
      endcase
      if (wr_hit) state_in = CFG_LOAD;
   end

   always_comb begin
      case (state_ff)
         CFG_IDLE: busy = 1'b0;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 13'd2;
         phase_ff    <= '0;
         dir_ff      <= 1'b0;
         strength_ff <= '0;
         state_ff    <= CFG_SETTLE;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WIDTH: width_ff <= csr_write_data;
               CSR_PHASE: phase_ff <= csr_write_data[11:0];
               CSR_DIR:   dir_ff   <= csr_write_data[0];
               default:   ;
            endcase
         end
         if (state_ff == CFG_ROUND)
            strength_ff <= ({2'b00, area} > round_lim) ? 8'(root_ff + 9'd1) : root_ff[7:0];
      end
   end

   // shift-subtract divide, then one root bit per cycle
   always_ff @(posedge clock) begin
      case (state_ff)
         CFG_LOAD: begin
            rem_ff  <= '0;
            quo_ff  <= num;
            cnt_ff  <= 5'd27;
            root_ff <= '0;
         end
         CFG_DIV: begin
            rem_ff <= ge ? 13'(rem_s - {1'b0, div_w}) : rem_s[12:0];
            quo_ff <= {quo_ff[26:0], ge};
            cnt_ff <= (cnt_ff == '0) ? 5'd7 : cnt_ff - 5'd1;
         end
         CFG_SQRT: begin
            if (trial_sq <= {2'b00, area}) root_ff <= trial;
            cnt_ff <= cnt_ff - 5'd1;
         end
         default: ;
      endcase
      cfg_ff <= cfg_in;
   end

   always_comb begin
      m   = (32'(phase_ff) < SHADE_BAND) ? phase_ff : 12'(SHADE_BAND);
      ws  = $signed({3'b000, weff});
      ps  = $signed({4'h0, phase_ff});
      ms  = $signed({4'h0, m});
      p3h = (ps + (ps <<< 1)) >>> 1;
      cfg_in.w       = weff;
      cfg_in.p       = phase_ff;
      cfg_in.dir     = dir_ff;
      cfg_in.m       = m;
      cfg_in.q       = strength_ff;
      cfg_in.hg      = strength_ff[7:1];
      cfg_in.ph_zero = (phase_ff == '0);
      cfg_in.ph_half = (phase_ff == half);
      if (!dir_ff) begin
         cfg_in.b1   = clamp_w(ws - (ps <<< 1) - ms, weff);
         cfg_in.b2   = clamp_w(ws - (ps <<< 1), weff);
         cfg_in.b3   = clamp_w(ws - p3h, weff);
         cfg_in.b4   = clamp_w(ws - ps, weff);
         cfg_in.s_lo = ws - (ps <<< 1);
         cfg_in.s_hi = (ws <<< 1) - (ps <<< 1);
      end else begin
         cfg_in.b1   = clamp_w(ps, weff);
         cfg_in.b2   = clamp_w(p3h, weff);
         cfg_in.b3   = clamp_w(ps <<< 1, weff);
         cfg_in.b4   = clamp_w((ps <<< 1) + ms, weff);
         cfg_in.s_lo = (ps <<< 1) - ws;
         cfg_in.s_hi = ps <<< 1;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/ptpc_prep.sv
// Band selection and shade numerator, two stages ahead of the divider chain.
`timescale 1ns / 1ps
module ptpc_prep import ptpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [11:0] column,
   input  logic [31:0] old_pixel,
   input  logic [31:0] new_pixel,
   input  logic [31:0] new_pixel_shifted,
   input  cfg_type     cfg,
   output logic        out_valid,
   output stage_type   out_stage
);

   logic               p0_valid_ff, out_valid_ff;
   logic signed [15:0] x_ff, x_in;
   logic [8:0]         qm_ff, qm_in;
   logic [DW-1:0]      d_ff, d_in;
   pix_type            pix_ff, pix_in;
   stage_type          out_ff, out_in;

   logic signed [15:0] cs, ws, ps, ms, b1s, b2s, b3s, b4s;
   logic               lt1, lt2, lt3, lt4, in_s2;
   logic [8:0]         q1, q2;
   logic [NW-1:0]      prod;

   always_comb begin
      cs  = $signed({4'h0, column});
      ws  = $signed({3'b000, cfg.w});
      ps  = $signed({4'h0, cfg.p});
      ms  = $signed({4'h0, cfg.m});
      b1s = $signed({3'b000, cfg.b1});
      b2s = $signed({3'b000, cfg.b2});
      b3s = $signed({3'b000, cfg.b3});
      b4s = $signed({3'b000, cfg.b4});
      lt1 = {1'b0, column} < cfg.b1;
      lt2 = {1'b0, column} < cfg.b2;
      lt3 = {1'b0, column} < cfg.b3;
      lt4 = {1'b0, column} < cfg.b4;
      in_s2 = (cs >= cfg.s_lo) && (cs < cfg.s_hi);
      q1 = {1'b0, cfg.q};
      q2 = {cfg.q, 1'b0};

      pix_in.old_pixel = old_pixel;
      pix_in.new_pixel = new_pixel;
      pix_in.shifted   = in_s2 ? new_pixel_shifted : '0;
      pix_in.hg        = cfg.hg;
      pix_in.half      = 1'b0;
      pix_in.sel       = SEL_OLD;
      x_in  = '0;
      qm_in = q1;
      d_in  = cfg.p;

      if (!cfg.dir) begin
         if (lt1) begin
            pix_in.sel = SEL_OLD;
         end else if (lt2) begin
            pix_in.sel  = SEL_DK_OLD;
            pix_in.half = 1'b1;
            x_in        = cs - b2s + ms;
            d_in        = cfg.m;
         end else if (lt3) begin
            pix_in.sel = SEL_LIGHT;
            x_in       = b3s - cs;
            qm_in      = q2;
         end else if (lt4) begin
            pix_in.sel = SEL_DARK;
            x_in       = ((cs - b4s) <<< 1) + ps;
         end else begin
            pix_in.sel = SEL_DK_NEW;
            x_in       = ws - cs;
         end
      end else begin
         if (lt1) begin
            pix_in.sel = SEL_DK_NEW;
            x_in       = b1s - cs;
         end else if (lt2) begin
            pix_in.sel = SEL_DARK;
            x_in       = b2s - cs;
            qm_in      = q2;
         end else if (lt3) begin
            pix_in.sel = SEL_LIGHT;
            x_in       = (ps >>> 1) + ((cs - b3s) <<< 1);
         end else if (lt4) begin
            pix_in.sel  = SEL_DK_OLD;
            pix_in.half = 1'b1;
            x_in        = b4s - cs;
            d_in        = cfg.m;
         end else begin
            pix_in.sel = SEL_OLD;
         end
      end

      if (cfg.ph_zero) pix_in.sel = SEL_OLD;
      else if (cfg.ph_half) pix_in.sel = SEL_NEW;
   end

   // negative numerators shade to nothing
   always_comb begin
      prod       = x_ff[14:0] * qm_ff;
      out_in.rem = '0;
      out_in.nq  = x_ff[15] ? '0 : prod;
      out_in.div = d_ff;
      out_in.pix = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff  <= in_valid;
         out_valid_ff <= p0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         qm_ff  <= qm_in;
         d_ff   <= d_in;
         pix_ff <= pix_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_ff;

endmodule

### rtl/ptpc_div_cell.sv
// One restoring-divide cell: yields one quotient bit and carries the pixel along.
`timescale 1ns / 1ps
module ptpc_div_cell import ptpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  stage_type in_stage,
   output logic      out_valid,
   output stage_type out_stage
);

   logic          valid_ff;
   stage_type     stage_ff, stage_in;
   logic [DW:0]   rem_s;
   logic          ge;

   always_comb begin
      rem_s        = {in_stage.rem, in_stage.nq[NW-1]};
      ge           = rem_s >= {1'b0, in_stage.div};
      stage_in     = in_stage;
      stage_in.rem = ge ? DW'(rem_s - {1'b0, in_stage.div}) : rem_s[DW-1:0];
      stage_in.nq  = {in_stage.nq[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### rtl/ptpc_blend.sv
// Shading of the channels, then crease mixing into the result register.
`timescale 1ns / 1ps
module ptpc_blend import ptpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  stage_type   in_stage,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel
);

   logic        e1_valid_ff, rsp_valid_ff;
   logic [31:0] a_ff, a_in, b_ff, b_in, old_ff, new_ff, rsp_ff, rsp_in;
   sel_type     sel_ff;
   logic [7:0]  al_ff;
   logic [NW-1:0] f;
   logic [31:0] f32, src;

   always_comb begin
      f   = in_stage.pix.half ? {1'b0, in_stage.nq[NW-1:1]} : in_stage.nq;
      f32 = {{(32 - NW){1'b0}}, f};
      case (in_stage.pix.sel)
         SEL_DK_OLD: src = in_stage.pix.old_pixel;
         SEL_DK_NEW: src = in_stage.pix.new_pixel;
         default:    src = in_stage.pix.shifted;
      endcase
      b_in = (in_stage.pix.sel == SEL_LIGHT) ? lighten(src, f32) : darken(src, f32);
      a_in = darken(in_stage.pix.old_pixel, {25'd0, in_stage.pix.hg});
   end

   always_comb begin
      case (sel_ff)
         SEL_OLD:    rsp_in = old_ff;
         SEL_NEW:    rsp_in = new_ff;
         SEL_DK_OLD: rsp_in = b_ff;
         SEL_DK_NEW: rsp_in = b_ff;
         SEL_LIGHT:  rsp_in = mix(a_ff, b_ff, {24'd0, al_ff}) | (old_ff & ALPHA_MASK);
         SEL_DARK:   rsp_in = mix(a_ff, b_ff, {24'd0, al_ff}) | (old_ff & ALPHA_MASK);
         default:    rsp_in = old_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff  <= in_valid;
         rsp_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         old_ff <= in_stage.pix.old_pixel;
         new_ff <= in_stage.pix.new_pixel;
         sel_ff <= in_stage.pix.sel;
         al_ff  <= in_stage.pix.shifted[31:24];
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_ff;

endmodule

### tb/sv/tb_page_turn_pixel_compositor.sv
// Self-checking testbench for the page-turn pixel compositor: directed table, then random beats.
`timescale 1ns / 1ps
module tb_page_turn_pixel_compositor;
   import ptpc_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int         FLUSH_CYCLES = 45;

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [12:0] data;
      logic [11:0] column;
      logic [31:0] old_px;
      logic [31:0] new_px;
      logic [31:0] shift_px;
      bit          known;
      logic [31:0] pixel;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_column = '0;
   logic [31:0] req_old_pixel = '0;
   logic [31:0] req_new_pixel = '0;
   logic [31:0] req_new_pixel_shifted = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_pixel;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_write_data = '0;

   logic [12:0] cur_width;
   logic [11:0] cur_phase;
   logic        cur_dir;
   logic [7:0]  cur_strength;

   logic [31:0] pixel_q[$];
   int          mismatches = 0;
   int          beats_checked = 0;
   int          beats_sent = 0;
   int          csr_writes = 0;
   bit          quiet = 1'b0;

   page_turn_pixel_compositor DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Timeout after %0d beats checked", beats_checked);
      $display("Test completed with failures");
      $finish;
   end

   function automatic void solve_strength();
      longint w, a, r, bit_v;
      w = (cur_width > 4096) ? 4096 : cur_width;
      a = 0;
      r = 0;
      if (w > 0) begin
         a = (((w / 2) - longint'(cur_phase)) * 65536) / w / 2;
         if (a < 0) a = 0;
      end
      for (bit_v = 65536; bit_v > 0; bit_v = bit_v >> 1)
         if ((r + bit_v) * (r + bit_v) <= a) r = r + bit_v;
      if (a > r * r + r) r = r + 1;
      cur_strength = r[7:0];
   endfunction

   function automatic logic [31:0] dim(logic [31:0] c, logic [31:0] f);
      logic [31:0] mask, t, r;
      r = c & 32'hff00_0000;
      for (int k = 0; k < 3; k++) begin
         mask = 32'hff << (8 * k);
         t = c & mask;
         r = r | ((t - ((t * f) >> 8)) & mask);
      end
      return r;
   endfunction

   function automatic logic [31:0] brighten(logic [31:0] c, logic [31:0] f);
      logic [31:0] mask, t, r;
      r = c & 32'hff00_0000;
      for (int k = 0; k < 3; k++) begin
         mask = 32'hff << (8 * k);
         t = c & mask;
         r = r | (((((mask - t) * f) >> 8) + t) & mask);
      end
      return r;
   endfunction

   function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] al);
      logic [31:0] mask, x, y, r;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         mask = 32'hff << (8 * k);
         x = a & mask;
         y = b & mask;
         r = r | (((((y - x) * al) >> 8) + x) & mask);
      end
      return r;
   endfunction

   function automatic logic [31:0] shade_of(longint f);
      return (f < 0) ? 32'd0 : f[31:0];
   endfunction

   function automatic longint clip(longint v, longint w);
      if (v < 0) v = 0;
      if (v > w) v = w;
      return v;
   endfunction

   function automatic logic [31:0] fold(logic [31:0] o, logic [31:0] s2, logic [31:0] f,
                                        bit light, logic [31:0] hg);
      logic [31:0] b;
      b = light ? brighten(s2, f) : dim(s2, f);
      return blend(dim(o, hg), b, s2 >> 24) | (o & 32'hff00_0000);
   endfunction

   function automatic logic [31:0] composite(logic [11:0] col, logic [31:0] o,
                                             logic [31:0] n, logic [31:0] sh);
      longint c, w, p, q, m, b1, b2, b3, b4, sc;
      logic [31:0] hg, s2;
      c = col;
      w = (cur_width > 4096) ? 4096 : cur_width;
      p = cur_phase;
      q = cur_strength;
      hg = 32'(q / 2);
      m = (p < 16) ? p : 16;
      if (p == 0) return o;
      if (p == w / 2) return n;
      if (!cur_dir) begin
         b1 = clip(w - 2 * p - m, w);
         b2 = clip(w - 2 * p, w);
         b3 = clip(w - (3 * p) / 2, w);
         b4 = clip(w - p, w);
         sc = c + 2 * p - w;
         s2 = (sc >= 0 && sc < w) ? sh : 32'd0;
         if (c < b1) return o;
         if (c < b2) return dim(o, shade_of((((c - b2) + m) * q / m) / 2));
         if (c < b3) return fold(o, s2, shade_of(((b3 - c) * q * 2) / p), 1'b1, hg);
         if (c < b4) return fold(o, s2, shade_of((((c - b4) * 2 + p) * q) / p), 1'b0, hg);
         return dim(n, shade_of(((w - c) * q) / p));
      end
      b1 = clip(p, w);
      b2 = clip((3 * p) / 2, w);
      b3 = clip(2 * p, w);
      b4 = clip(2 * p + m, w);
      sc = c + w - 2 * p;
      s2 = (sc >= 0 && sc < w) ? sh : 32'd0;
      if (c < b1) return dim(n, shade_of(((b1 - c) * q) / p));
      if (c < b2) return fold(o, s2, shade_of(((b2 - c) * q * 2) / p), 1'b0, hg);
      if (c < b3) return fold(o, s2, shade_of(((p / 2 + (c - b3) * 2) * q) / p), 1'b1, hg);
      if (c < b4) return dim(o, shade_of((((b4 - c) * q) / m) / 2));
      return o;
   endfunction

   // called at a falling edge; valid drops before the next rising edge
   task automatic settle();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_WIDTH: begin cur_width = data; solve_strength(); end
         CSR_PHASE: begin cur_phase = data[11:0]; solve_strength(); end
         CSR_DIR: begin cur_dir = data[0]; solve_strength(); end
         default: ;
      endcase
   endtask

   // valid stays high between back-to-back beats; gaps are dropped in before a beat
   task automatic send_pixel(logic [11:0] col, logic [31:0] o, logic [31:0] n,
                             logic [31:0] sh, bit known, logic [31:0] pixel);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_column <= col;
      req_old_pixel <= o;
      req_new_pixel <= n;
      req_new_pixel_shifted <= sh;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixel_q.push_back(known ? pixel : composite(col, o, n, sh));
      beats_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin : rsp_backpressure
      int hold;
      if (quiet || reset) begin
         hold = 0;
         rsp_stall <= 1'b0;
      end else if (hold > 0) begin
         hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 6) == 0) begin
         hold = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected beat: out_pixel %h", rsp_out_pixel);
         end else begin
            want = pixel_q.pop_front();
            beats_checked++;
            if (rsp_out_pixel !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch on beat %0d: out_pixel expected %h got %h",
                           beats_checked, want, rsp_out_pixel);
            end
         end
      end
   end

   function automatic row_type px(logic [11:0] c, logic [31:0] o, logic [31:0] n,
                                  logic [31:0] s, bit k = 0, logic [31:0] e = 0);
      row_type r;
      r = '{default: 0};
      r.column = c; r.old_px = o; r.new_px = n; r.shift_px = s; r.known = k; r.pixel = e;
      return r;
   endfunction

   function automatic row_type cs(logic [1:0] idx, logic [12:0] data);
      row_type r;
      r = '{default: 0};
      r.is_csr = 1; r.idx = idx; r.data = data;
      return r;
   endfunction

   function automatic logic [31:0] rand_px();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[31:24] = 8'h00;
         1: v[31:24] = 8'hff;
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      row_type plan[$];
      int w, p, n, span;
      logic [11:0] col;
      cur_width = 13'd2;
      cur_phase = '0;
      cur_dir = 1'b0;
      cur_strength = '0;

      // phase zero passes old, half width passes new, the spare index is dropped; later rows shade
      plan = '{
         px(12'd0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 1, 32'h0),
         px(12'd4095, 32'hffff_ffff, 32'h0, 32'h0, 1, 32'hffff_ffff),
         px(12'd1, 32'h1234_5678, 32'h8765_4321, 32'h5555_aaaa, 1, 32'h1234_5678),
         cs(CSR_WIDTH, 13'd64), cs(CSR_PHASE, 13'd32),
         px(12'd10, 32'h1111_1111, 32'hcafe_f00d, 32'h0, 1, 32'hcafe_f00d),
         cs(CSR_SPARE, 13'h1fff),
         px(12'd63, 32'h0, 32'hdead_beef, 32'hffff_ffff, 1, 32'hdead_beef),
         cs(CSR_WIDTH, 13'h1fff), cs(CSR_PHASE, 13'd2048),
         px(12'd4095, 32'h0, 32'h0bad_cafe, 32'h0, 1, 32'h0bad_cafe),
         cs(CSR_WIDTH, 13'd40), cs(CSR_PHASE, 13'd8),
         px(12'd0, 32'hff80_4020, 32'h0, 32'hffff_ffff),
         px(12'd20, 32'hff80_4020, 32'h0, 32'hffff_ffff),
         px(12'd27, 32'h80ff_ffff, 32'h0, 32'hff00_0000),
         px(12'd33, 32'h80ff_ffff, 32'hffff_ffff, 32'hffff_ffff),
         px(12'd39, 32'h0, 32'hffff_ffff, 32'h0),
         cs(CSR_DIR, 13'd1),
         px(12'd3, 32'h0, 32'hffff_ffff, 32'hffff_ffff),
         px(12'd13, 32'hffff_ffff, 32'h0, 32'h7f7f_7f7f),
         px(12'd22, 32'hffff_ffff, 32'h0, 32'h0),
         cs(CSR_WIDTH, 13'd0), cs(CSR_PHASE, 13'd5),
         px(12'd2, 32'habcd_ef01, 32'h1357_9bdf, 32'hffff_ffff),
         cs(CSR_WIDTH, 13'd20), cs(CSR_PHASE, 13'd4095),
         px(12'd4095, 32'hffff_ffff, 32'h0123_4567, 32'hffff_ffff),
         cs(CSR_DIR, 13'd0),
         px(12'd30, 32'hffff_ffff, 32'h89ab_cdef, 32'hffff_ffff)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            send_pixel(plan[i].column, plan[i].old_px, plan[i].new_px, plan[i].shift_px,
                       plan[i].known, plan[i].pixel);
         end
      end

      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: begin w = 4096; p = 1; end
            1: begin w = 4096; p = 2047; end
            2: begin w = 8191; p = 100; end
            3: begin w = 2; p = 1; end
            4: begin w = 3; p = 1; end
            default: begin
               w = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096)
                                                : $urandom_range(2, 300);
               p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1, w / 2);
            end
         endcase
         settle();
         write_csr(CSR_WIDTH, w[12:0]);
         write_csr(CSR_PHASE, p[12:0]);
         write_csr(CSR_DIR, (ph % 2 == 0) ? 13'd1 : 13'd0);
         if (ph == 13) quiet = 1'b1;
         n = (ph < 2) ? 20 : 50;
         span = (w > 4096) ? 4096 : w;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) col = 12'($urandom_range(0, 4095));
            else col = 12'($urandom_range(0, span - 1));
            send_pixel(col, rand_px(), rand_px(), rand_px(), 1'b0, 32'h0);
         end
      end

      req_valid <= 1'b0;
      settle();
      $display("Covered %0d pixel beats over %0d register writes, %0d results checked",
               beats_sent, csr_writes, beats_checked);
      $display("Both fold directions, phase zero and half width, clamped widths and phases");
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, pixel_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
